FILE: src/pidis_pkg.sv
// Shared types and constants of the PID controller with integral separation
`default_nettype none

package pidis_pkg;

	// word format: signed two's complement, FRAC_BITS fraction bits
	localparam int DATA_WIDTH      = 32;
	localparam int FRAC_BITS       = 16;
	localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
	localparam int MAG_WIDTH       = DATA_WIDTH - 1;
	localparam int CFG_INDEX_WIDTH = 3;

	// register reset values: limit wide open, gate 10.0, integral clamp 100.0
	localparam logic [MAG_WIDTH-1:0] OUT_LIMIT_RESET      = {MAG_WIDTH{1'b1}};
	localparam logic [MAG_WIDTH-1:0] ERROR_GATE_RESET     = MAG_WIDTH'(64'd10 << FRAC_BITS);
	localparam logic [MAG_WIDTH-1:0] INTEGRAL_LIMIT_RESET = MAG_WIDTH'(64'd100 << FRAC_BITS);

	// configuration register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_KP             = 3'd0,
		CFG_KI             = 3'd1,
		CFG_KD             = 3'd2,
		CFG_OUT_LIMIT      = 3'd3,
		CFG_ERROR_GATE     = 3'd4,
		CFG_INTEGRAL_LIMIT = 3'd5
	} cfg_reg_t;

	// input word
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] target;
		logic signed [DATA_WIDTH-1:0] measured;
	} pid_in_t;

	// result word
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] drive;
		logic                         integral_active;
		logic                         drive_clamped;
	} pid_out_t;

endpackage

`default_nettype wire

FILE: src/pidis_scale.sv
// Fixed-point rescale of one full product: truncate toward zero, saturate to a word
`default_nettype none

module pidis_scale (
	input  wire logic signed [pidis_pkg::PROD_WIDTH-1:0] prod,
	output logic signed [pidis_pkg::DATA_WIDTH-1:0]      term
);
	import pidis_pkg::*;

	localparam logic signed [PROD_WIDTH-1:0] BIAS =
		PROD_WIDTH'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [PROD_WIDTH-1:0] biased;
	logic signed [PROD_WIDTH-1:0] shifted;
	logic [PROD_WIDTH-DATA_WIDTH:0] top_bits;

	// negative products get a bias so the arithmetic shift rounds toward zero
	assign biased   = prod + (prod[PROD_WIDTH-1] ? BIAS : '0);
	assign shifted  = biased >>> FRAC_BITS;
	assign top_bits = shifted[PROD_WIDTH-1:DATA_WIDTH-1];

	// saturate when the upper bits are not a plain sign extension
	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			term = shifted[DATA_WIDTH-1:0];
		end else if (shifted[PROD_WIDTH-1]) begin
			term = WORD_MIN;
		end else begin
			term = WORD_MAX;
		end
	end

endmodule

`default_nettype wire

FILE: src/pid_integral_separation.sv
// Top level of the positional PID controller with integral separation
//
// Positional PID controller, signed Q16.16. Each input word carries a target and a
// measurement; the block forms error = target - measured, its difference from the
// previous error, a saturating integral clamped to +/- integral_limit, and
// drive = kp*error + ki*integral + kd*difference clamped to +/- out_limit. The
// integral term counts only while |error| <= error_gate (integral_active tells
// which). While out_ready does not stall the pipeline, the block takes one word per
// cycle and throughput is one word per clock. That rate is held by the
// error/integral update in the first stage, which closes its feedback through its
// state registers; the three multiplies, the rescale and the final sum and clamp
// each get a stage of their own. Configuration registers are written by the user
// through cfg_wen/cfg_index/cfg_data only while no word is in flight, which the
// block does not enforce; writes to indexes beyond integral_limit are ignored.
`default_nettype none

module pid_integral_separation (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wen,
	input  wire logic [pidis_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [pidis_pkg::DATA_WIDTH-1:0]       cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire pidis_pkg::pid_in_t                     in_word,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output pidis_pkg::pid_out_t                         out_word
);
	import pidis_pkg::*;

	localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [PROD_WIDTH-1:0] PROD_ZERO = '0;

	// saturate a one-bit-grown sum to a word
	function automatic logic signed [DATA_WIDTH-1:0] sat_word(
		input logic signed [DATA_WIDTH:0] x
	);
		logic signed [DATA_WIDTH-1:0] r;
		if (x[DATA_WIDTH] == x[DATA_WIDTH-1]) begin
			r = x[DATA_WIDTH-1:0];
		end else if (x[DATA_WIDTH]) begin
			r = WORD_MIN;
		end else begin
			r = WORD_MAX;
		end
		return r;
	endfunction

	// configuration registers
	logic signed [DATA_WIDTH-1:0] kp_q, ki_q, kd_q;
	logic [MAG_WIDTH-1:0]         out_limit_q, error_gate_q, integral_limit_q;

	// controller state
	logic signed [DATA_WIDTH-1:0] prev_error_q, integral_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_out;

	// pipeline payload
	pid_in_t                      in_s1;
	logic signed [DATA_WIDTH-1:0] err_s2, diff_s2, integ_s2;
	logic                         gate_s2, gate_s3, gate_s4;
	logic signed [PROD_WIDTH-1:0] prod_p_s3, prod_i_s3, prod_d_s3;
	logic signed [DATA_WIDTH-1:0] term_p_s4, term_i_s4, term_d_s4;
	pid_out_t                     out_q;

	// stage-one combinational values
	logic signed [DATA_WIDTH-1:0] err, diff, integ_raw, integ_new;
	logic signed [DATA_WIDTH-1:0] ilim, ilim_neg;
	logic [DATA_WIDTH-1:0]        err_mag;
	logic                         gate;

	// scale outputs and final sum
	logic signed [DATA_WIDTH-1:0] term_p, term_i, term_d;
	logic signed [DATA_WIDTH+1:0] sum_wide;
	logic signed [DATA_WIDTH-1:0] sum_sat, olim, olim_neg, drive;
	logic                         clamped;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q             <= '0;
			ki_q             <= '0;
			kd_q             <= '0;
			out_limit_q      <= OUT_LIMIT_RESET;
			error_gate_q     <= ERROR_GATE_RESET;
			integral_limit_q <= INTEGRAL_LIMIT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_KP:             kp_q             <= cfg_data;
				CFG_KI:             ki_q             <= cfg_data;
				CFG_KD:             kd_q             <= cfg_data;
				CFG_OUT_LIMIT:      out_limit_q      <= cfg_data[MAG_WIDTH-1:0];
				CFG_ERROR_GATE:     error_gate_q     <= cfg_data[MAG_WIDTH-1:0];
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[MAG_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// backpressure chain: a stage loads when empty or when it drains this cycle
	assign ready_out = !out_valid_q || out_ready;
	assign ready_s4  = !v_s4 || ready_out;
	assign ready_s3  = !v_s3 || ready_s4;
	assign ready_s2  = !v_s2 || ready_s3;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_ready  = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
			if (ready_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			in_s1 <= in_word;
		end
	end

	// stage one: error, difference, gate and integral update
	assign err      = sat_word({in_s1.target[DATA_WIDTH-1], in_s1.target}
		- {in_s1.measured[DATA_WIDTH-1], in_s1.measured});
	assign diff     = sat_word({err[DATA_WIDTH-1], err} - {prev_error_q[DATA_WIDTH-1], prev_error_q});
	assign err_mag  = err[DATA_WIDTH-1] ? (~err + 1'b1) : err;
	assign gate     = err_mag <= {1'b0, error_gate_q};
	assign integ_raw = sat_word({integral_q[DATA_WIDTH-1], integral_q} + {err[DATA_WIDTH-1], err});
	assign ilim     = {1'b0, integral_limit_q};
	assign ilim_neg = -ilim;

	always_comb begin
		if (integ_raw < ilim_neg) begin
			integ_new = ilim_neg;
		end else if (integ_raw > ilim) begin
			integ_new = ilim;
		end else begin
			integ_new = integ_raw;
		end
	end

	// state advances as each word leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integral_q   <= '0;
		end else if (v_s1 && ready_s2) begin
			prev_error_q <= err;
			integral_q   <= integ_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			err_s2   <= err;
			diff_s2  <= diff;
			integ_s2 <= integ_new;
			gate_s2  <= gate;
		end
	end

	// stage two: the three gain products, integral product dropped when gated off
	always_ff @(posedge clk) begin
		if (ready_s3) begin
			prod_p_s3 <= kp_q * err_s2;
			prod_i_s3 <= gate_s2 ? (ki_q * integ_s2) : PROD_ZERO;
			prod_d_s3 <= kd_q * diff_s2;
			gate_s3   <= gate_s2;
		end
	end

	// stage three: rescale each product to a saturated word
	pidis_scale u_scale_p (.prod(prod_p_s3), .term(term_p));
	pidis_scale u_scale_i (.prod(prod_i_s3), .term(term_i));
	pidis_scale u_scale_d (.prod(prod_d_s3), .term(term_d));

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			term_p_s4 <= term_p;
			term_i_s4 <= term_i;
			term_d_s4 <= term_d;
			gate_s4   <= gate_s3;
		end
	end

	// stage four: exact sum, one saturation, then the output clamp
	assign sum_wide = {{2{term_p_s4[DATA_WIDTH-1]}}, term_p_s4}
		+ {{2{term_i_s4[DATA_WIDTH-1]}}, term_i_s4}
		+ {{2{term_d_s4[DATA_WIDTH-1]}}, term_d_s4};
	assign olim     = {1'b0, out_limit_q};
	assign olim_neg = -olim;

	always_comb begin
		if ((&sum_wide[DATA_WIDTH+1:DATA_WIDTH-1]) || !(|sum_wide[DATA_WIDTH+1:DATA_WIDTH-1])) begin
			sum_sat = sum_wide[DATA_WIDTH-1:0];
		end else if (sum_wide[DATA_WIDTH+1]) begin
			sum_sat = WORD_MIN;
		end else begin
			sum_sat = WORD_MAX;
		end
	end

	always_comb begin
		if (sum_sat < olim_neg) begin
			drive   = olim_neg;
			clamped = 1'b1;
		end else if (sum_sat > olim) begin
			drive   = olim;
			clamped = 1'b1;
		end else begin
			drive   = sum_sat;
			clamped = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ready_out && v_s4) begin
			out_q.drive           <= drive;
			out_q.integral_active <= gate_s4;
			out_q.drive_clamped   <= clamped;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// state only moves when a word leaves stage one
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && ready_s2) |=> $stable(prev_error_q) && $stable(integral_q))
		else $error("controller state changed without a word leaving stage one");

	// a stalled stage four keeps its word
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !ready_out |=> v_s4 && $stable(term_p_s4) && $stable(term_i_s4)
			&& $stable(term_d_s4))
		else $error("stage four lost or changed a stalled word");

	// an accepted word always lands in stage one
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word did not enter stage one");

	// a word gated off carries no integral product
	a_gate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && ready_s3 && !gate_s2 |=> !gate_s3 && (prod_i_s3 == '0))
		else $error("integral product present while the gate was closed");

endmodule

`default_nettype wire

FILE: dv/pid_drive_checker.sv
// Checker that predicts and compares the drive words of the PID controller
`timescale 1ns / 100ps

module pid_drive_checker
	import pidis_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [DATA_WIDTH-1:0]      cfg_data,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire pid_in_t                    in_word,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire pid_out_t                   out_word,
	output int                              mismatches,
	output int                              pending
);

	localparam longint WORD_HI = (longint'(1) << (DATA_WIDTH - 1)) - 1;
	localparam longint WORD_LO = -(longint'(1) << (DATA_WIDTH - 1));
	localparam int     SHOWN_MISMATCHES = 10;

	// shadow of the register file
	longint gain_p, gain_i, gain_d;
	longint drive_limit, gate_level, integral_clamp;

	// controller state as the block should hold it
	longint last_error, integral_acc;

	// drive words still owed by the block, oldest first
	pid_out_t owed_drive_q[$];
	pid_out_t owed;

	// clip to the signed word range
	function automatic longint clip_word(input longint x);
		if (x > WORD_HI) return WORD_HI;
		if (x < WORD_LO) return WORD_LO;
		return x;
	endfunction

	// exact product, rescaled with truncation toward zero, then clipped
	function automatic longint scaled_product(input longint gain, input longint operand);
		longint p;
		p = gain * operand;
		if (p < 0)
			p = -((-p) >>> FRAC_BITS);
		else
			p = p >>> FRAC_BITS;
		return clip_word(p);
	endfunction

	// one control step: updates the state and returns the drive word it causes
	function automatic pid_out_t predict_drive(input pid_in_t w);
		longint   err, diff, mag, p_term, i_term, d_term, sum;
		logic     gate_open;
		pid_out_t r;
		err  = clip_word(longint'($signed(w.target)) - longint'($signed(w.measured)));
		diff = clip_word(err - last_error);
		mag  = (err < 0) ? -err : err;
		gate_open = (mag <= gate_level);

		// integral always accumulates, then gets its symmetric clamp
		integral_acc = clip_word(integral_acc + err);
		if (integral_acc > integral_clamp)
			integral_acc = integral_clamp;
		else if (integral_acc < -integral_clamp)
			integral_acc = -integral_clamp;

		p_term = scaled_product(gain_p, err);
		i_term = gate_open ? scaled_product(gain_i, integral_acc) : 0;
		d_term = scaled_product(gain_d, diff);
		sum    = clip_word(p_term + i_term + d_term);

		// output clamp
		r.drive_clamped = 1'b0;
		if (sum > drive_limit) begin
			sum = drive_limit;
			r.drive_clamped = 1'b1;
		end else if (sum < -drive_limit) begin
			sum = -drive_limit;
			r.drive_clamped = 1'b1;
		end

		last_error = err;
		r.drive = sum[DATA_WIDTH-1:0];
		r.integral_active = gate_open;
		return r;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p         = 0;
			gain_i         = 0;
			gain_d         = 0;
			drive_limit    = longint'(OUT_LIMIT_RESET);
			gate_level     = longint'(ERROR_GATE_RESET);
			integral_clamp = longint'(INTEGRAL_LIMIT_RESET);
			last_error     = 0;
			integral_acc   = 0;
			owed_drive_q.delete();
			mismatches     = 0;
			pending        = 0;
		end else begin
			// register writes, masked to each register's width
			if (cfg_wen) begin
				case (cfg_index)
					CFG_KP:             gain_p = longint'($signed(cfg_data));
					CFG_KI:             gain_i = longint'($signed(cfg_data));
					CFG_KD:             gain_d = longint'($signed(cfg_data));
					CFG_OUT_LIMIT:      drive_limit = longint'(cfg_data[MAG_WIDTH-1:0]);
					CFG_ERROR_GATE:     gate_level = longint'(cfg_data[MAG_WIDTH-1:0]);
					CFG_INTEGRAL_LIMIT: integral_clamp = longint'(cfg_data[MAG_WIDTH-1:0]);
					default: ;
				endcase
			end

			// compare an accepted result word with the oldest prediction
			if (out_valid && out_ready) begin
				if (owed_drive_q.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("unexpected result word: drive=%0d active=%0b clamped=%0b",
							out_word.drive, out_word.integral_active,
							out_word.drive_clamped);
				end else begin
					owed = owed_drive_q.pop_front();
					if (out_word.drive !== owed.drive ||
						out_word.integral_active !== owed.integral_active ||
						out_word.drive_clamped !== owed.drive_clamped) begin
						mismatches++;
						if (mismatches <= SHOWN_MISMATCHES)
							$display({"drive word mismatch: expected drive=%0d active=%0b ",
								"clamped=%0b, got drive=%0d active=%0b clamped=%0b"},
								owed.drive, owed.integral_active, owed.drive_clamped,
								out_word.drive, out_word.integral_active,
								out_word.drive_clamped);
					end
				end
			end

			// predict the result of an accepted input word
			if (in_valid && in_ready)
				owed_drive_q.push_back(predict_drive(in_word));

			pending = owed_drive_q.size();
		end
	end

endmodule

FILE: dv/tb_pid_integral_separation.sv
// Testbench top: stimulus, register phases and verdict for the PID controller
`timescale 1ns / 100ps

module tb_pid_integral_separation;
	import pidis_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 66;
	localparam int Q_ONE           = 1 << FRAC_BITS;
	localparam int TRACK_SPAN      = 20 * Q_ONE;
	localparam int TAIL_CYCLES     = 8;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic [DATA_WIDTH-1:0] W_MAX  = {1'b0, {MAG_WIDTH{1'b1}}};
	localparam logic [DATA_WIDTH-1:0] W_MIN  = {1'b1, {MAG_WIDTH{1'b0}}};
	localparam logic [DATA_WIDTH-1:0] W_ONES = '1;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       cfg_wen   = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [DATA_WIDTH-1:0]      cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	pid_in_t                    in_word   = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	pid_out_t                   out_word;

	int                         mismatches;
	int                         pending;
	int                         cycle_count   = 0;
	int                         send_idle_pct = 0;
	int                         stall_pct     = 0;
	logic [DATA_WIDTH-1:0]      cur_gate      = '0;

	pid_integral_separation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	pid_drive_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// data value: mostly near zero, some wide, some full range, corner values or powers of two
	function automatic logic [DATA_WIDTH-1:0] sample_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return int'($urandom_range(2 * TRACK_SPAN)) - TRACK_SPAN;
			4, 5:       return int'($urandom_range(1 << 26)) - (1 << 25);
			6, 7:       return $urandom();
			8: begin
				case ($urandom_range(4))
					0:       return W_MAX;
					1:       return W_MIN;
					2:       return '0;
					3:       return W_ONES;
					default: return 1;
				endcase
			end
			default:    return 1 << $urandom_range(DATA_WIDTH - 1);
		endcase
	endfunction

	// gain: mostly within +/-8.0
	function automatic logic [DATA_WIDTH-1:0] sample_gain();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return int'($urandom_range(16 * Q_ONE)) - 8 * Q_ONE;
			6, 7:             return $urandom();
			8:                return $urandom_range(1) ? W_MAX : W_MIN;
			default:          return $urandom_range(1) ? 1 : W_ONES;
		endcase
	endfunction

	// limit: masked by the block, so the top bit is random
	function automatic logic [DATA_WIDTH-1:0] sample_limit();
		logic [MAG_WIDTH-1:0] lim;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: lim = MAG_WIDTH'($urandom_range(200 * Q_ONE));
			5, 6:          lim = MAG_WIDTH'($urandom());
			7:             lim = '0;
			8:             lim = '1;
			default:       lim = 1;
		endcase
		return {1'($urandom_range(1)), lim};
	endfunction

	task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [DATA_WIDTH-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// program every register, plus one write past the list
	task automatic load_settings(input logic [DATA_WIDTH-1:0] kp, ki, kd,
		input logic [DATA_WIDTH-1:0] out_lim, gate, int_lim);
		put_reg(CFG_KP, kp);
		put_reg(CFG_KI, ki);
		put_reg(CFG_KD, kd);
		put_reg(CFG_OUT_LIMIT, out_lim);
		put_reg(CFG_ERROR_GATE, gate);
		put_reg(CFG_INTEGRAL_LIMIT, int_lim);
		put_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
		cfg_wen  <= 1'b0;
		cur_gate  = {1'b0, gate[MAG_WIDTH-1:0]};
	endtask

	// offer one input word, with random sender gaps ahead of it
	task automatic send_word(input logic [DATA_WIDTH-1:0] tgt, meas);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		in_word.target   <= tgt;
		in_word.measured <= meas;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [DATA_WIDTH-1:0] tgt, meas, delta;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: gains zero, gate at 10.0
		send_word(10 * Q_ONE, 0);
		send_word(0, 10 * Q_ONE + 1);
		send_word(W_MAX, 0);
		wait_drained();

		// gate edges, saturating error, integral wind-up and drive clamp
		load_settings(Q_ONE, Q_ONE / 2, -(Q_ONE / 4),
			{1'b1, MAG_WIDTH'(50 * Q_ONE)}, 10 * Q_ONE, 100 * Q_ONE);
		send_word(0, 0);
		send_word(10 * Q_ONE, 0);
		send_word(10 * Q_ONE + 1, 0);
		send_word(0, 10 * Q_ONE);
		send_word(0, 10 * Q_ONE + 1);
		send_word(W_MAX, W_MIN);
		send_word(W_MIN, W_MAX);
		send_word(W_MAX, W_MAX);
		send_word(W_MIN, W_MIN);
		send_word(W_ONES, 0);
		send_word(1, 0);
		repeat (4) send_word(9 * Q_ONE, 0);
		wait_drained();

		// zero limits force the drive, the gate and the integral to zero
		load_settings(W_MAX, Q_ONE, W_MIN, W_MIN, '0, {1'b1, {MAG_WIDTH{1'b0}}});
		send_word(0, 0);
		send_word(1, 0);
		send_word(0, 1);
		send_word(W_MAX, 0);
		send_word(W_MIN, W_MAX);
		send_word(0, 0);
		wait_drained();

		// random phases, each idling mode twice
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle_pct = 0;
			stall_pct     = 0;
			if (p == 0)
				load_settings(W_MAX, W_MAX, W_MAX, W_ONES, W_ONES, W_ONES);
			else if (p == 1)
				load_settings(W_MIN, W_MIN, W_MIN, sample_limit(), sample_limit(),
					sample_limit());
			else
				load_settings(sample_gain(), sample_gain(), sample_gain(),
					sample_limit(), sample_limit(), sample_limit());
			case (p % 4)
				1: send_idle_pct = 63;
				2: stall_pct = 63;
				3: begin
					send_idle_pct = 13;
					stall_pct     = 13;
				end
				default: ;
			endcase

			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				tgt = sample_value();
				case ($urandom_range(9))
					// measurement tracking the target: error mostly inside the gate
					0, 1, 2, 3, 4:
						meas = tgt - (int'($urandom_range(2 * TRACK_SPAN)) - TRACK_SPAN);
					// error right at the gate edge
					5: begin
						delta = cur_gate + $urandom_range(2) - 1;
						meas  = $urandom_range(1) ? tgt - delta : tgt + delta;
					end
					default: meas = sample_value();
				endcase
				send_word(tgt, meas);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
